// File: rtl/keyed_window_burst_detector_core_macros.svh
// Assertion macros for the keyed window burst detector.
`ifndef KEYED_WINDOW_BURST_DETECTOR_CORE_MACROS_SVH
`define KEYED_WINDOW_BURST_DETECTOR_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define KWBD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define KWBD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kwbd_pkg.sv
// Package: sizes, register indexes, config and state types of the burst detector.
`timescale 1ns / 1ps
package kwbd_pkg;
  localparam int NumKeys    = 64;
  localparam int KeyW       = 6;
  localparam int MaxRecords = 1024;
  localparam int TsW        = 20;
  localparam int AddrW      = $clog2(MaxRecords);
  localparam int CntW       = $clog2(MaxRecords + 1);
  localparam int EmitW      = $clog2(NumKeys + 1);
  localparam int RecW       = TsW + KeyW;
  localparam int WinW       = 20;
  localparam int MinW       = 11;
  localparam int CfgDataW   = 20;

  localparam logic CfgWindowLen = 1'b0;
  localparam logic CfgMinCount  = 1'b1;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncRun  = 1'b1;

  typedef struct packed {
    logic [WinW-1:0] window_len;
    logic [MinW-1:0] min_count;
  } cfg_t;

  typedef enum logic [2:0] {
    StIdle,
    StOuterRd,
    StOuterCap,
    StScan,
    StCheck,
    StEmit
  } state_e;
endpackage

// File: rtl/keyed_window_burst_detector_core.sv
// Top level: configuration registers, detector engine and checks.
// Load: one per cycle while idle; start_i writes the record straight into the RAM (dropped when full), no result.
// Run: a pairwise scan of the n stored records, bound by the one RAM port, then a walk over all NumKeys keys.
// Results come one per strobe during the final key walk; the receiver cannot stall.
// Reset clears record count, dropped flag, state; window_len resets to 10, min_count to 2.
`timescale 1ns / 1ps
`include "keyed_window_burst_detector_core_macros.svh"
module keyed_window_burst_detector_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [kwbd_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             func_i,
  input  logic [kwbd_pkg::TsW-1:0]         timestamp_i,
  input  logic [kwbd_pkg::KeyW-1:0]        key_id_i,
  output logic                             res_valid_o,
  output logic [kwbd_pkg::KeyW-1:0]        hot_key_o,
  output logic                             found_o,
  output logic                             last_o,
  output logic                             overflow_o
);
  kwbd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len <= kwbd_pkg::WinW'(10);
      cfg_q.min_count  <= kwbd_pkg::MinW'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kwbd_pkg::CfgWindowLen: cfg_q.window_len <= cfg_wdata_i[kwbd_pkg::WinW-1:0];
        kwbd_pkg::CfgMinCount:  cfg_q.min_count  <= cfg_wdata_i[kwbd_pkg::MinW-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  kwbd_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (start_i),
    .func_i     (func_i),
    .timestamp_i(timestamp_i),
    .key_id_i   (key_id_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .hot_key_o  (hot_key_o),
    .found_o    (found_o),
    .last_o     (last_o),
    .overflow_o (overflow_o)
  );

  `KWBD_ASSERT_IMP(a_mid_busy, res_valid_o && !last_o, busy_o, "non-final result while idle")
  `KWBD_ASSERT_IMP(a_last_idle, res_valid_o && last_o, !busy_o, "final result while busy")
  `KWBD_ASSERT_IMP(a_none_last, res_valid_o && !found_o, last_o, "empty result not final")
  `KWBD_ASSERT_NXT(a_run_busy, start_i && !busy_o && func_i, busy_o, "run did not start")
endmodule

// File: rtl/kwbd_ram.sv
// Generic single-port synchronous RAM with registered read.
`timescale 1ns / 1ps
module kwbd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/kwbd_engine.sv
// Engine: record load, pairwise window scan over the record RAM, and hot key emission.
`timescale 1ns / 1ps
module kwbd_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  kwbd_pkg::cfg_t               cfg_i,
  input  logic                         start_i,
  input  logic                         func_i,
  input  logic [kwbd_pkg::TsW-1:0]     timestamp_i,
  input  logic [kwbd_pkg::KeyW-1:0]    key_id_i,
  output logic                         busy_o,
  output logic                         res_valid_o,
  output logic [kwbd_pkg::KeyW-1:0]    hot_key_o,
  output logic                         found_o,
  output logic                         last_o,
  output logic                         overflow_o
);
  kwbd_pkg::state_e state_q, state_d;

  logic [kwbd_pkg::CntW-1:0]    cnt_q, i_q, j_q, match_q;
  logic                         drop_q, rv_q;
  logic [kwbd_pkg::TsW-1:0]     ref_ts_q;
  logic [kwbd_pkg::KeyW-1:0]    ref_key_q;
  logic [kwbd_pkg::NumKeys-1:0] hot_q;
  logic [kwbd_pkg::EmitW-1:0]   e_q;
  logic [kwbd_pkg::KeyW-1:0]    pend_q;
  logic                         have_q;
  logic                         vld_q, found_q, last_q, ovf_q;
  logic [kwbd_pkg::KeyW-1:0]    key_q;

  logic                         ram_we;
  logic [kwbd_pkg::AddrW-1:0]   ram_addr;
  logic [kwbd_pkg::RecW-1:0]    ram_wdata, ram_rdata;
  logic [kwbd_pkg::TsW-1:0]     rd_ts, diff;
  logic [kwbd_pkg::KeyW-1:0]    rd_key;
  logic                         accept, load_acc, run_acc, issue, hit, scan_done, emit_end;
  logic [kwbd_pkg::MinW-1:0]    eff_k;

  assign accept    = start_i && (state_q == kwbd_pkg::StIdle);
  assign load_acc  = accept && (func_i == kwbd_pkg::FuncLoad);
  assign run_acc   = accept && (func_i == kwbd_pkg::FuncRun);
  assign issue     = j_q < cnt_q;
  assign scan_done = !issue && !rv_q;
  assign emit_end  = e_q == kwbd_pkg::EmitW'(kwbd_pkg::NumKeys);
  assign rd_ts     = ram_rdata[kwbd_pkg::RecW-1:kwbd_pkg::KeyW];
  assign rd_key    = ram_rdata[kwbd_pkg::KeyW-1:0];
  assign diff      = rd_ts - ref_ts_q;
  assign hit       = rv_q && (rd_key == ref_key_q) && (rd_ts >= ref_ts_q)
                     && (diff < cfg_i.window_len);
  assign eff_k     = (cfg_i.min_count == '0) ? kwbd_pkg::MinW'(1) : cfg_i.min_count;
  assign ram_wdata = {timestamp_i, key_id_i};

  kwbd_ram #(
    .Width(kwbd_pkg::RecW),
    .Depth(kwbd_pkg::MaxRecords)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      kwbd_pkg::StIdle: begin
        if (run_acc) begin
          state_d = (cnt_q == '0) ? kwbd_pkg::StEmit : kwbd_pkg::StOuterRd;
        end
      end
      kwbd_pkg::StOuterRd:  state_d = kwbd_pkg::StOuterCap;
      kwbd_pkg::StOuterCap: state_d = kwbd_pkg::StScan;
      kwbd_pkg::StScan: begin
        if (scan_done) begin
          state_d = kwbd_pkg::StCheck;
        end
      end
      kwbd_pkg::StCheck: begin
        state_d = (i_q + 1'b1 == cnt_q) ? kwbd_pkg::StEmit : kwbd_pkg::StOuterRd;
      end
      kwbd_pkg::StEmit: begin
        if (emit_end) begin
          state_d = kwbd_pkg::StIdle;
        end
      end
      default: state_d = kwbd_pkg::StIdle;
    endcase
  end

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = cnt_q[kwbd_pkg::AddrW-1:0];
    case (state_q)
      kwbd_pkg::StIdle: ram_we = load_acc && (cnt_q < kwbd_pkg::CntW'(kwbd_pkg::MaxRecords));
      kwbd_pkg::StOuterRd: ram_addr = i_q[kwbd_pkg::AddrW-1:0];
      kwbd_pkg::StScan: ram_addr = j_q[kwbd_pkg::AddrW-1:0];
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kwbd_pkg::StIdle;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      rv_q    <= 1'b0;
      match_q <= '0;
      hot_q   <= '0;
      e_q     <= '0;
      have_q  <= 1'b0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= 1'b0;
      case (state_q)
        kwbd_pkg::StIdle: begin
          if (load_acc) begin
            if (cnt_q < kwbd_pkg::CntW'(kwbd_pkg::MaxRecords)) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              drop_q <= 1'b1;
            end
          end
          if (run_acc) begin
            i_q    <= '0;
            e_q    <= '0;
            have_q <= 1'b0;
            hot_q  <= '0;
          end
        end
        kwbd_pkg::StOuterCap: begin
          ref_ts_q  <= rd_ts;
          ref_key_q <= rd_key;
          j_q       <= '0;
          match_q   <= '0;
          rv_q      <= 1'b0;
        end
        kwbd_pkg::StScan: begin
          if (issue) begin
            j_q <= j_q + 1'b1;
          end
          rv_q <= issue;
          if (hit) begin
            match_q <= match_q + 1'b1;
          end
        end
        kwbd_pkg::StCheck: begin
          if (match_q >= kwbd_pkg::CntW'(eff_k)) begin
            hot_q[ref_key_q] <= 1'b1;
          end
          i_q <= i_q + 1'b1;
        end
        kwbd_pkg::StEmit: begin
          ovf_q <= drop_q;
          if (!emit_end) begin
            e_q <= e_q + 1'b1;
            if (hot_q[e_q[kwbd_pkg::KeyW-1:0]]) begin
              pend_q  <= e_q[kwbd_pkg::KeyW-1:0];
              have_q  <= 1'b1;
              vld_q   <= have_q;
              key_q   <= pend_q;
              found_q <= 1'b1;
              last_q  <= 1'b0;
            end
          end else begin
            vld_q   <= 1'b1;
            key_q   <= have_q ? pend_q : '0;
            found_q <= have_q;
            last_q  <= 1'b1;
            cnt_q   <= '0;
            drop_q  <= 1'b0;
          end
        end
        default: vld_q <= 1'b0;
      endcase
    end
  end

  assign busy_o      = state_q != kwbd_pkg::StIdle;
  assign res_valid_o = vld_q;
  assign hot_key_o   = key_q;
  assign found_o     = found_q;
  assign last_o      = last_q;
  assign overflow_o  = ovf_q;
endmodule
